// ----- rtl/adaptive_frame_rate_governor_macros.svh -----
// assertion macros for the adaptive frame rate governor
// the asserting module must provide clk and rst_n
`ifndef ADAPTIVE_FRAME_RATE_GOVERNOR_MACROS_SVH
`define ADAPTIVE_FRAME_RATE_GOVERNOR_MACROS_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle
`define AFRG_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the next cycle
`define AFRG_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AFRG_ASSERT_SAME(name, ante, cons, msg)
`define AFRG_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- rtl/afrg_pkg.sv -----
// shared types and constants of the adaptive frame rate governor
// no dependencies
package afrg_pkg;

    localparam int RATE_W     = 10;
    localparam int PERIOD_W   = 10;
    localparam int STREAK_W   = 8;
    localparam int WORK_W     = 16;
    localparam int CHANGE_W   = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;
    localparam int OUT_DATA_W = 24;
    localparam int DIV_CNT_W  = $clog2(RATE_W);

    localparam int MS_PER_SECOND_INT = 1000;
    localparam logic [PERIOD_W-1:0] MS_PER_SECOND = PERIOD_W'(MS_PER_SECOND_INT);
    localparam logic [STREAK_W-1:0] STREAK_MAX    = 8'd255;

    localparam int RESET_TARGET_INT = 60;
    localparam logic [RATE_W-1:0]   RESET_MIN_RATE    = 10'd30;
    localparam logic [RATE_W-1:0]   RESET_TARGET_RATE = RATE_W'(RESET_TARGET_INT);
    localparam logic [RATE_W-1:0]   RESET_RATE_STEP   = 10'd5;
    localparam logic [PERIOD_W-1:0] RESET_TOLERANCE   = 10'd2;
    localparam logic [PERIOD_W-1:0] RESET_HEADROOM    = 10'd4;
    localparam logic [STREAK_W-1:0] RESET_OVER_NEED   = 8'd3;
    localparam logic [STREAK_W-1:0] RESET_UNDER_NEED  = 8'd30;
    localparam logic [PERIOD_W-1:0] RESET_PERIOD =
        PERIOD_W'(MS_PER_SECOND_INT / RESET_TARGET_INT);

    typedef enum logic [CHANGE_W-1:0] {
        CHG_NONE = 2'd0,
        CHG_DOWN = 2'd1,
        CHG_UP   = 2'd2
    } rate_change_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_MIN_RATE   = 3'd0,
        REG_TARGET     = 3'd1,
        REG_STEP       = 3'd2,
        REG_TOLERANCE  = 3'd3,
        REG_HEADROOM   = 3'd4,
        REG_OVER_NEED  = 3'd5,
        REG_UNDER_NEED = 3'd6
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- rtl/afrg_div.sv -----
// iterative restoring divider: ms per second divided by a rate, one bit per cycle
// depends on afrg_pkg
module afrg_div import afrg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [RATE_W-1:0]   divisor,
    output div_status_t         status,
    output logic [PERIOD_W-1:0] quotient
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [RATE_W-1:0]    rem_reg;
    logic [RATE_W-1:0]    dsr_reg;
    logic [PERIOD_W-1:0]  quo_reg;
    logic [RATE_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg, MS_PER_SECOND[cnt_reg]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(PERIOD_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? RATE_W'(trial - {1'b0, dsr_reg}) : trial[RATE_W-1:0];
            quo_reg <= {quo_reg[PERIOD_W-2:0], fits};
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ----- rtl/adaptive_frame_rate_governor.sv -----
// adaptive frame rate governor: one work-time beat in, one rate beat out.
// when no divide is needed a frame goes from idle straight to the output state; when
// the rate is adjusted to a nonzero value, the new period first goes through the
// bit-serial divider; the input stays not ready until the result is loaded into the
// output register, and waits longer only while an earlier result is not taken.
// depends on afrg_pkg, afrg_div and adaptive_frame_rate_governor_macros.svh
`include "adaptive_frame_rate_governor_macros.svh"

module adaptive_frame_rate_governor import afrg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [WORK_W-1:0]     s_tdata,   // work_ms[15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // frame_rate[9:0], frame_period_ms[19:10],
                                             // rate_change[21:20], zero[23:22]
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_OUT  = 3'b100
    } state_t;

    localparam int SUM_W = WORK_W + 1;

    // configuration
    logic [RATE_W-1:0]   min_rate_reg;
    logic [RATE_W-1:0]   target_reg;
    logic [RATE_W-1:0]   step_reg;
    logic [PERIOD_W-1:0] tol_reg;
    logic [PERIOD_W-1:0] head_reg;
    logic [STREAK_W-1:0] over_need_reg;
    logic [STREAK_W-1:0] under_need_reg;

    // governor state
    state_t              state_reg, state_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [STREAK_W-1:0] over_reg, over_next;
    logic [STREAK_W-1:0] under_reg, under_next;
    rate_change_t        change_reg, change_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    logic                div_start;
    div_status_t         div_status;
    logic [PERIOD_W-1:0] div_quotient;

    logic [SUM_W-1:0]    work_ext;
    logic [SUM_W-1:0]    over_limit;
    logic [SUM_W-1:0]    under_sum;
    logic                is_over;
    logic                is_under;
    logic [STREAK_W-1:0] over_bump;
    logic [STREAK_W-1:0] under_bump;
    logic [RATE_W-1:0]   down_rate;
    logic [RATE_W:0]     up_sum;
    logic [RATE_W-1:0]   up_rate;
    logic                adjust;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rate_reg   <= RESET_MIN_RATE;
            target_reg     <= RESET_TARGET_RATE;
            step_reg       <= RESET_RATE_STEP;
            tol_reg        <= RESET_TOLERANCE;
            head_reg       <= RESET_HEADROOM;
            over_need_reg  <= RESET_OVER_NEED;
            under_need_reg <= RESET_UNDER_NEED;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_MIN_RATE:   min_rate_reg   <= cfg_wdata;
                REG_TARGET:     target_reg     <= cfg_wdata;
                REG_STEP:       step_reg       <= cfg_wdata;
                REG_TOLERANCE:  tol_reg        <= cfg_wdata;
                REG_HEADROOM:   head_reg       <= cfg_wdata;
                REG_OVER_NEED:  over_need_reg  <= cfg_wdata[STREAK_W-1:0];
                REG_UNDER_NEED: under_need_reg <= cfg_wdata[STREAK_W-1:0];
                default:        ;
            endcase
        end
    end

    // frame classification and candidate rates
    assign work_ext   = {1'b0, s_tdata};
    assign over_limit = SUM_W'(period_reg) + SUM_W'(tol_reg);
    assign under_sum  = work_ext + SUM_W'(head_reg);
    assign is_over    = work_ext > over_limit;
    assign is_under   = (under_sum < SUM_W'(period_reg)) && (rate_reg < target_reg);
    assign over_bump  = (over_reg == STREAK_MAX) ? STREAK_MAX : over_reg + 1'b1;
    assign under_bump = (under_reg == STREAK_MAX) ? STREAK_MAX : under_reg + 1'b1;
    assign down_rate  = (rate_reg < step_reg || (rate_reg - step_reg) < min_rate_reg)
                        ? min_rate_reg : rate_reg - step_reg;
    assign up_sum     = {1'b0, rate_reg} + {1'b0, step_reg};
    assign up_rate    = (up_sum > {1'b0, target_reg}) ? target_reg : up_sum[RATE_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        rate_next     = rate_reg;
        period_next   = period_reg;
        over_next     = over_reg;
        under_next    = under_reg;
        change_next   = change_reg;
        out_data_next = out_data_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        div_start     = 1'b0;
        adjust        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next  = ST_OUT;
                    change_next = CHG_NONE;
                    if (is_over)
                    begin
                        under_next = '0;
                        if (over_bump >= over_need_reg && rate_reg > min_rate_reg)
                        begin
                            adjust    = 1'b1;
                            rate_next = down_rate;
                            over_next = '0;
                            if (down_rate != rate_reg)
                                change_next = CHG_DOWN;
                        end
                        else
                            over_next = over_bump;
                    end
                    else if (is_under)
                    begin
                        over_next = '0;
                        if (under_bump >= under_need_reg)
                        begin
                            adjust     = 1'b1;
                            rate_next  = up_rate;
                            under_next = '0;
                            if (up_rate != rate_reg)
                                change_next = CHG_UP;
                        end
                        else
                            under_next = under_bump;
                    end
                    else
                    begin
                        over_next  = '0;
                        under_next = '0;
                    end
                    if (adjust)
                    begin
                        if (rate_next == '0)
                            period_next = MS_PER_SECOND;
                        else
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    period_next = div_quotient;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_data_next = {2'b00, change_reg, period_reg, rate_reg};
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rate_reg     <= RESET_TARGET_RATE;
            period_reg   <= RESET_PERIOD;
            over_reg     <= '0;
            under_reg    <= '0;
            change_reg   <= CHG_NONE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rate_reg     <= rate_next;
            period_reg   <= period_next;
            over_reg     <= over_next;
            under_reg    <= under_next;
            change_reg   <= change_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    afrg_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (rate_next),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;

    `AFRG_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready,
        "input ready right after an accepted beat")
    `AFRG_ASSERT_SAME(a_start_when_free, div_start, !div_status.busy,
        "divider started while busy")
    `AFRG_ASSERT_SAME(a_done_in_div, div_status.done, state_reg == ST_DIV,
        "divider finished outside the divide state")
    `AFRG_ASSERT_NEXT(a_div_to_out, state_reg == ST_DIV && div_status.done,
        state_reg == ST_OUT, "no output step after the divide")

endmodule

// ----- verif/afrg_checker.sv -----
`timescale 1ns / 100ps
// checker for the adaptive frame rate governor: follows register writes, predicts the
// rate beat of every accepted work beat and compares it with the output stream
// depends on afrg_pkg
module afrg_checker import afrg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [WORK_W-1:0]     s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    fail_count,
    output int                    pending,
    output logic [PERIOD_W-1:0]   predicted_period
);

    typedef struct packed {
        logic [1:0]          pad;
        rate_change_t        change;
        logic [PERIOD_W-1:0] period;
        logic [RATE_W-1:0]   rate;
    } rate_beat_t;

    int unsigned min_rate;
    int unsigned target_rate;
    int unsigned rate_step;
    int unsigned tolerance_ms;
    int unsigned headroom_ms;
    int unsigned over_need;
    int unsigned under_need;

    int unsigned gov_rate;
    int unsigned gov_period;
    int unsigned over_streak;
    int unsigned under_streak;

    int errors = 0;
    rate_beat_t rate_beats_q[$];

    function automatic int unsigned period_for(input int unsigned rate);
        if (rate == 0)
            return MS_PER_SECOND_INT;
        return MS_PER_SECOND_INT / rate;
    endfunction

    function automatic int unsigned streak_inc(input int unsigned streak);
        return (streak >= int'(STREAK_MAX)) ? int'(STREAK_MAX) : streak + 1;
    endfunction

    function automatic rate_beat_t govern(input logic [WORK_W-1:0] work);
        int unsigned w;
        int unsigned old_rate;
        int unsigned next;
        rate_beat_t beat;
        w = work;
        old_rate = gov_rate;
        beat.pad = '0;
        beat.change = CHG_NONE;
        if (w > gov_period + tolerance_ms)
        begin
            over_streak = streak_inc(over_streak);
            under_streak = 0;
            if (over_streak >= over_need && gov_rate > min_rate)
            begin
                if (gov_rate < rate_step || gov_rate - rate_step < min_rate)
                    next = min_rate;
                else
                    next = gov_rate - rate_step;
                gov_rate = next;
                gov_period = period_for(gov_rate);
                over_streak = 0;
                if (gov_rate != old_rate)
                    beat.change = CHG_DOWN;
            end
        end
        else if (w + headroom_ms < gov_period && gov_rate < target_rate)
        begin
            under_streak = streak_inc(under_streak);
            over_streak = 0;
            if (under_streak >= under_need)
            begin
                next = gov_rate + rate_step;
                if (next > target_rate)
                    next = target_rate;
                gov_rate = next;
                gov_period = period_for(gov_rate);
                under_streak = 0;
                if (gov_rate != old_rate)
                    beat.change = CHG_UP;
            end
        end
        else
        begin
            over_streak = 0;
            under_streak = 0;
        end
        beat.rate = RATE_W'(gov_rate);
        beat.period = PERIOD_W'(gov_period);
        return beat;
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rate_beat_t got;
        rate_beat_t want;
        if (!rst_n)
        begin
            min_rate = RESET_MIN_RATE;
            target_rate = RESET_TARGET_RATE;
            rate_step = RESET_RATE_STEP;
            tolerance_ms = RESET_TOLERANCE;
            headroom_ms = RESET_HEADROOM;
            over_need = RESET_OVER_NEED;
            under_need = RESET_UNDER_NEED;
            gov_rate = RESET_TARGET_RATE;
            gov_period = period_for(gov_rate);
            over_streak = 0;
            under_streak = 0;
            rate_beats_q.delete();
            pending <= 0;
            predicted_period <= PERIOD_W'(gov_period);
            fail_count <= errors;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    REG_MIN_RATE:   min_rate = cfg_wdata;
                    REG_TARGET:     target_rate = cfg_wdata;
                    REG_STEP:       rate_step = cfg_wdata;
                    REG_TOLERANCE:  tolerance_ms = cfg_wdata;
                    REG_HEADROOM:   headroom_ms = cfg_wdata;
                    REG_OVER_NEED:  over_need = cfg_wdata[STREAK_W-1:0];
                    REG_UNDER_NEED: under_need = cfg_wdata[STREAK_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (rate_beats_q.size() == 0)
                    flag_error($sformatf("rate beat with nothing expected: rate %0d period %0d change %0d",
                        got.rate, got.period, got.change));
                else
                begin
                    want = rate_beats_q.pop_front();
                    if (got.rate !== want.rate || got.period !== want.period
                        || got.change !== want.change || got.pad !== want.pad)
                        flag_error($sformatf({"rate beat mismatch: expected rate %0d period %0d ",
                            "change %0d pad %0d, got rate %0d period %0d change %0d pad %0d"},
                            want.rate, want.period, want.change, want.pad,
                            got.rate, got.period, got.change, got.pad));
                end
            end
            if (s_tvalid && s_tready)
                rate_beats_q.push_back(govern(s_tdata));
            pending <= rate_beats_q.size();
            predicted_period <= PERIOD_W'(gov_period);
            fail_count <= errors;
        end
    end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// top of the governor testbench: clock, reset, register writes, work beats and verdict
// depends on afrg_pkg, afrg_checker and the adaptive_frame_rate_governor rtl
module tb;
    import afrg_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_ITEMS = 1500;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORK_W-1:0]     s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;

    int                  fail_count;
    int                  pending;
    logic [PERIOD_W-1:0] predicted_period;

    int send_idle_pct = 12;
    int recv_idle_pct = 66;
    int items_sent = 0;
    int cycles = 0;
    int unsigned cur_tol = RESET_TOLERANCE;
    int unsigned cur_headroom = RESET_HEADROOM;

    adaptive_frame_rate_governor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    afrg_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .fail_count       (fail_count),
        .pending          (pending),
        .predicted_period (predicted_period)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_work(input logic [WORK_W-1:0] work);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= work;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // sender holds off until every rate beat has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (idx == REG_TOLERANCE)
            cur_tol = value;
        if (idx == REG_HEADROOM)
            cur_headroom = value;
    endtask

    function automatic logic [CFG_DATA_W-1:0] reg_value(input int lo, input int hi);
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(hi, lo));
        endcase
    endfunction

    task automatic shuffle_regs();
        for (int i = 0; i <= REG_UNDER_NEED; i++)
        begin
            if ($urandom_range(1))
            begin
                case (cfg_index_t'(i))
                    REG_MIN_RATE:   write_reg(REG_MIN_RATE, reg_value(1, 50));
                    REG_TARGET:     write_reg(REG_TARGET, reg_value(40, 150));
                    REG_STEP:       write_reg(REG_STEP, reg_value(0, 20));
                    REG_TOLERANCE:  write_reg(REG_TOLERANCE, reg_value(0, 8));
                    REG_HEADROOM:   write_reg(REG_HEADROOM, reg_value(0, 8));
                    REG_OVER_NEED:  write_reg(REG_OVER_NEED, reg_value(0, 6));
                    REG_UNDER_NEED: write_reg(REG_UNDER_NEED, reg_value(0, 6));
                    default: ;
                endcase
            end
        end
        if ($urandom_range(7) == 0)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
    endtask

    function automatic logic [WORK_W-1:0] pick_work(input int kind);
        int unsigned p;
        int unsigned edge_hi;
        p = predicted_period;
        edge_hi = p + cur_tol;
        case (kind)
            0, 1, 2: return WORK_W'(edge_hi + 1 + $urandom_range(3));
            3:       return WORK_W'($urandom_range(65535, edge_hi + 1));
            4, 5, 6: return (p > cur_headroom) ? WORK_W'($urandom_range(p - cur_headroom - 1, 0))
                                               : '0;
            7:       return $urandom_range(1) ? WORK_W'(edge_hi)
                                              : WORK_W'((p >= cur_headroom) ? p - cur_headroom : 0);
            8:       return WORK_W'($urandom);
            default: return WORK_W'($urandom_range(edge_hi, 0));
        endcase
    endfunction

    task automatic run_frames(input int count);
        int kind;
        int run_len;
        int done;
        done = 0;
        while (done < count)
        begin
            kind = $urandom_range(9);
            run_len = $urandom_range(20, 1);
            repeat (run_len)
            begin
                send_work(pick_work(kind));
                done++;
            end
        end
    endtask

    // overrun streak held at the lowest rate long enough to saturate, then released
    task automatic streak_saturation();
        write_reg(REG_MIN_RATE, '1);
        write_reg(REG_OVER_NEED, CFG_DATA_W'(STREAK_MAX));
        repeat (300)
            send_work(WORK_W'($urandom_range(65535, 2100)));
        drain();
        write_reg(REG_MIN_RATE, '0);
        write_reg(REG_STEP, 10'd1);
        send_work('1);
    endtask

    initial
    begin
        int phase;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: extremes of work and a first step down
        send_work('0);
        repeat (3) send_work('1);
        send_work(WORK_W'(20));
        send_work(WORK_W'(21));
        send_work('0);
        drain();
        write_reg(REG_UNDER_NEED, 10'd1);
        send_work(WORK_W'(13));
        send_work('0);
        // zero frames needed and zero step
        drain();
        write_reg(REG_OVER_NEED, 10'd0);
        write_reg(REG_STEP, 10'd0);
        send_work('1);
        // step clamped down to a zero rate, then up to the target
        drain();
        write_reg(REG_STEP, 10'd1000);
        write_reg(REG_MIN_RATE, 10'd0);
        send_work('1);
        drain();
        write_reg(REG_UNDER_NEED, 10'd0);
        send_work('0);
        // widest tolerance and headroom, 8-bit register fed 10 bits, unknown index
        drain();
        write_reg(REG_TOLERANCE, '1);
        write_reg(REG_HEADROOM, '1);
        write_reg(REG_UNDER_NEED, '1);
        write_reg(REG_UNUSED, 10'h2AA);
        send_work('1);
        send_work('0);
        send_work(WORK_W'(999));
        drain();
        write_reg(REG_TARGET, '1);
        write_reg(REG_MIN_RATE, 10'd1);
        write_reg(REG_TOLERANCE, 10'd0);
        write_reg(REG_HEADROOM, 10'd0);
        send_work(WORK_W'(1001));
        send_work('0);

        phase = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent < RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 12;
                recv_idle_pct = 66;
            end
            else if (items_sent < 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 66;
                recv_idle_pct = 12;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            drain();
            shuffle_regs();
            if (phase == 2)
                streak_saturation();
            else
                run_frames($urandom_range(120, 60));
            phase++;
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
